>>> src/mwt_pkg.sv
// ----------------------------------------------------------------------------
// mwt_pkg
// Commands, register indexes and fixed constants of the window trigger.
// ----------------------------------------------------------------------------
package mwt_pkg;

  localparam int CMD_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int NUM_CH_W   = 6;
  localparam int WORD_W     = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE = 3'd0,
    CMD_END    = 3'd1,
    CMD_WRITE  = 3'd2,
    CMD_READ   = 3'd3,
    CMD_ARM    = 3'd4
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WORD_SIZE    = 2'd0,
    CFG_NUM_CHANNELS = 2'd1,
    CFG_EVAL_ENABLE  = 2'd2
  } cfg_idx_t;

  // word size codes in bytes
  localparam logic [2:0] WS_16 = 3'd2;
  localparam logic [2:0] WS_24 = 3'd3;
  localparam logic [2:0] WS_32 = 3'd4;

  localparam logic [NUM_CH_W-1:0] NUM_CH_RESET = 6'd32;

  // limits after reset: plus or minus 0x7fffffff
  localparam logic [WORD_W-1:0] LIMIT_HI_RESET = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] LIMIT_LO_RESET = 32'h8000_0001;

endpackage

>>> src/multichannel_window_trigger.sv
// ----------------------------------------------------------------------------
// multichannel_window_trigger
// Window comparator over a stream of channel samples with block-end trigger.
// ----------------------------------------------------------------------------
// Takes one item per clock while the output does not stall. Acceptance
// registers the item together with the limit-table read (one read port per
// table, addressed by the running channel position or by chan_index) into the
// input register; from there the sign extension, the window compare and the
// trigger update go into the result register. Stall on the output holds the
// result and the input register; the limit tables carry one valid bit per
// entry, so they read as plus or minus 0x7fffffff from reset with no
// clearing pass.
module multichannel_window_trigger #(
  parameter int MAX_CHANNELS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic                           cfg_write,
  input  logic [mwt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mwt_pkg::CFG_DATA_W-1:0] cfg_data,
  // input items
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           cmd,
  input  logic [31:0]          sample,
  input  logic [4:0]           chan_index,
  input  logic signed [31:0]   low_limit,
  input  logic signed [31:0]   high_limit,
  // result items
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 trig_out,
  output logic [31:0]          trigger_total,
  output logic                 block_hit,
  output logic signed [31:0]   read_low,
  output logic signed [31:0]   read_high
);

  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NW = (AW + 1 > 7) ? AW + 1 : 7;

  // configuration registers
  logic [2:0]                        word_size;
  logic [mwt_pkg::NUM_CH_W-1:0]      num_channels;
  logic                              eval_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_size    <= mwt_pkg::WS_16;
      num_channels <= mwt_pkg::NUM_CH_RESET;
      eval_enable  <= 1'b1;
    end else if (cfg_write) begin
      unique case (mwt_pkg::cfg_idx_t'(cfg_index))
        mwt_pkg::CFG_WORD_SIZE:    word_size    <= cfg_data[2:0];
        mwt_pkg::CFG_NUM_CHANNELS: num_channels <= cfg_data;
        mwt_pkg::CFG_EVAL_ENABLE:  eval_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // handshake
  logic s1_valid;
  logic res_load_ok;
  logic s1_fire;
  logic in_fire;

  assign res_load_ok = !out_valid || !out_stall;
  assign s1_fire     = s1_valid && res_load_ok;
  assign in_stall    = s1_valid && !res_load_ok;
  assign in_fire     = in_valid && !in_stall;

  // channel index widened so it can be compared and cut to the table depth
  logic [AW+4:0]  idx_wide;
  logic [AW-1:0]  idx_addr;
  logic           idx_ok;

  assign idx_wide = {{AW{1'b0}}, chan_index};
  assign idx_addr = idx_wide[AW-1:0];
  assign idx_ok   = idx_wide < (AW+5)'(MAX_CHANNELS);

  // channel position, advanced as samples are accepted and cleared at block end
  logic [AW-1:0]  chan_pos;
  logic [AW-1:0]  chan_pos_next;
  logic [NW-1:0]  n_active;
  logic [NW-1:0]  pos_inc;

  always_comb begin
    if (num_channels == '0) begin
      n_active = NW'(1);
    end else if (NW'(num_channels) > NW'(MAX_CHANNELS)) begin
      n_active = NW'(MAX_CHANNELS);
    end else begin
      n_active = NW'(num_channels);
    end
    pos_inc       = NW'(chan_pos) + NW'(1);
    chan_pos_next = chan_pos;
    if (cmd == mwt_pkg::CMD_SAMPLE) begin
      chan_pos_next = (pos_inc >= n_active) ? '0 : pos_inc[AW-1:0];
    end else if (cmd == mwt_pkg::CMD_END) begin
      chan_pos_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_pos <= '0;
    end else if (in_fire) begin
      chan_pos <= chan_pos_next;
    end
  end

  // limit tables
  logic [31:0]             lo_mem [MAX_CHANNELS];
  logic [31:0]             hi_mem [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] lim_valid;
  logic [AW-1:0]           rd_addr;
  logic                    wr_en;

  assign rd_addr = (cmd == mwt_pkg::CMD_READ) ? idx_addr : chan_pos;
  assign wr_en   = in_fire && (cmd == mwt_pkg::CMD_WRITE) && idx_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lo_mem[idx_addr] <= low_limit;
      hi_mem[idx_addr] <= high_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lim_valid <= '0;
    end else if (wr_en) begin
      lim_valid[idx_addr] <= 1'b1;
    end
  end

  // input register
  logic [2:0]   s1_cmd;
  logic [31:0]  s1_sample;
  logic         s1_idx_ok;
  logic [31:0]  s1_lo;
  logic [31:0]  s1_hi;
  logic         s1_lim_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd       <= cmd;
      s1_sample    <= sample;
      s1_idx_ok    <= idx_ok;
      s1_lo        <= lo_mem[rd_addr];
      s1_hi        <= hi_mem[rd_addr];
      s1_lim_valid <= lim_valid[rd_addr];
    end
  end

  // compare and trigger update
  logic signed [31:0] x;
  logic signed [31:0] lo;
  logic signed [31:0] hi;
  logic               outside;
  logic               hit_flag;
  logic               hit_flag_next;
  logic               out_level;
  logic               out_level_next;
  logic [31:0]        trig_counter;
  logic [31:0]        trig_counter_next;
  logic [31:0]        rd_lo_next;
  logic [31:0]        rd_hi_next;

  always_comb begin
    unique case (word_size)
      mwt_pkg::WS_32: x = s1_sample;
      mwt_pkg::WS_24: x = {{8{s1_sample[23]}}, s1_sample[23:0]};
      default:        x = {{16{s1_sample[15]}}, s1_sample[15:0]};
    endcase
    lo      = s1_lim_valid ? s1_lo : mwt_pkg::LIMIT_LO_RESET;
    hi      = s1_lim_valid ? s1_hi : mwt_pkg::LIMIT_HI_RESET;
    // equal limits switch the channel off
    outside = (lo != hi) && ((x > hi) || (x < lo));

    hit_flag_next     = hit_flag;
    out_level_next    = out_level;
    trig_counter_next = trig_counter;
    rd_lo_next        = '0;
    rd_hi_next        = '0;
    unique case (s1_cmd)
      mwt_pkg::CMD_SAMPLE: begin
        if (outside) begin
          hit_flag_next = 1'b1;
        end
      end
      mwt_pkg::CMD_END: begin
        if (eval_enable) begin
          if (hit_flag) begin
            if (!out_level) begin
              out_level_next    = 1'b1;
              trig_counter_next = trig_counter + 32'd1;
            end
          end else begin
            out_level_next = 1'b0;
          end
        end
        hit_flag_next = 1'b0;
      end
      mwt_pkg::CMD_READ: begin
        if (s1_idx_ok) begin
          rd_lo_next = lo;
          rd_hi_next = hi;
        end
      end
      mwt_pkg::CMD_ARM: begin
        trig_counter_next = '0;
        out_level_next    = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_flag     <= 1'b0;
      out_level    <= 1'b0;
      trig_counter <= '0;
    end else if (s1_fire) begin
      hit_flag     <= hit_flag_next;
      out_level    <= out_level_next;
      trig_counter <= trig_counter_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      trig_out      <= out_level_next;
      trigger_total <= trig_counter_next;
      block_hit     <= hit_flag_next;
      read_low      <= rd_lo_next;
      read_high     <= rd_hi_next;
    end
  end

  // a new trigger always counts exactly once
  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(out_level)) |-> trig_counter == $past(trig_counter) + 32'd1)
    else $error("trigger rise without count step");

  // input held back only while the input register is occupied
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with empty input register");

  // block end always leaves a clean block
  assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_cmd == mwt_pkg::CMD_END) |=> !hit_flag)
    else $error("hit flag survived block end");

  // only a limit read gives limit data
  assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_cmd != mwt_pkg::CMD_READ) |=> (read_low == '0 && read_high == '0))
    else $error("limit data on a non-read item");

endmodule
